### rtl/srfp_pkg.sv
// ----------------------------------------------------------------------------
// srfp_pkg - shared types and constants for the reply frame parser
// Command codes, scaling constants, the table row layout and the decoded
// operation handed from the framing stage to the table stage.
// ----------------------------------------------------------------------------
package srfp_pkg;

   // Default highest drive address on the bus.
   localparam int MaxAddrDefault = 32;

   // Encoder counts per revolution; the division is done as a shift, so this
   // must stay a power of two.
   localparam int          CountsPerRev = 65536;
   localparam int          RevShift     = $clog2(CountsPerRev);
   localparam logic [31:0] HalfRev      = 32'(CountsPerRev / 2);
   localparam logic [11:0] PosScale     = 12'd3600;
   localparam logic [3:0]  SpeedScale   = 4'd10;

   localparam logic [7:0] CheckReset = 8'd107;

   // Reply command codes.
   localparam logic [7:0] CmdSpeed    = 8'h35;
   localparam logic [7:0] CmdPosition = 8'h36;
   localparam logic [7:0] CmdShortF3  = 8'hF3;
   localparam logic [7:0] CmdShortF6  = 8'hF6;
   localparam logic [7:0] CmdShortFd  = 8'hFD;
   localparam logic [7:0] CmdShortFe  = 8'hFE;

   // Result kinds.
   localparam logic [1:0] KindByte  = 2'd0;
   localparam logic [1:0] KindFrame = 2'd1;
   localparam logic [1:0] KindQuery = 2'd2;

   // One drive's stored status.
   typedef struct packed {
      logic [15:0]        update;
      logic signed [20:0] speed;
      logic signed [31:0] pos;
   } row_type;

   // Decoded work for one beat, passed to the table stage.
   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         addr;
      logic [7:0]         cmd;
      logic               in_range;
      logic               wr_speed;
      logic               wr_pos;
      logic signed [20:0] speed;
      logic signed [31:0] pos;
   } op_type;

   // Frame length in bytes for a command, zero for an unknown command.
   function automatic logic [3:0] frame_len(input logic [7:0] cmd);
      logic [3:0] len;
      unique case (cmd)
         CmdSpeed:    len = 4'd6;
         CmdPosition: len = 4'd8;
         CmdShortF3, CmdShortF6, CmdShortFd, CmdShortFe: len = 4'd4;
         default:     len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

### rtl/stepper_reply_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// stepper_reply_frame_parser_unit - motor bus reply frame parser
// Assembles reply frames from received bus bytes, keeps a status row per
// drive address, and answers queries for a drive's stored status.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Contents
//   req_     in         req_tvalid/req_tready  one bus byte or one query
//   rsp_     out        rsp_tvalid/rsp_tready  one result per request beat
//   csr_     in         csr_we                 check byte register
//
// The unit takes one beat per cycle while req_tready is high. Each request
// beat is registered into the table stage as its row is read, and is then
// merged into the result register. The table is a RAM with a per-entry
// valid bit, so after reset every row reads as zero at once and no clearing
// pass is needed. When rsp_tready is low the result register and the table
// stage hold, and req_tready drops only when both of them are full.
// ----------------------------------------------------------------------------
module stepper_reply_frame_parser_unit #(
   parameter int MAX_ADDR = srfp_pkg::MaxAddrDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] rx_byte, [15:8] query_addr
   input  logic [15:0] req_tdata,
   // [0] opcode: 0 bus byte, 1 query
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] drive_addr, [15:8] reply_cmd, [47:16] position_tenth_deg,
   // [68:48] speed_tenth_rpm, [84:69] update_count, [87:85] zero
   output logic [87:0] rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   srfp_pkg::op_type  op;
   srfp_pkg::row_type rsp_row;
   logic              req_accept;
   logic [7:0]        rsp_addr;
   logic [7:0]        rsp_cmd;

   // The framing state only moves when a beat is really taken.
   assign req_accept = req_tvalid && req_tready;

   // Stage one: framing, length and check byte, and scaling of the
   // speed and position values. The slow arithmetic is done on the data
   // bytes before the check byte arrives, so the last byte only needs a
   // rounding add and a sign select.
   srfp_frame #(
      .MAX_ADDR (MAX_ADDR)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .opcode     (req_tuser),
      .rx_byte    (req_tdata[7:0]),
      .query_addr (req_tdata[15:8]),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .op         (op)
   );

   // Stage two: status table read-modify-write and the result register.
   srfp_table #(
      .MAX_ADDR (MAX_ADDR)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .op_in     (op),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_tuser),
      .rsp_addr  (rsp_addr),
      .rsp_cmd   (rsp_cmd),
      .rsp_row   (rsp_row)
   );

   // Result fields packed from the lowest bit up, padded to whole bytes.
   assign rsp_tdata = {3'b000, rsp_row.update, rsp_row.speed, rsp_row.pos,
                       rsp_cmd, rsp_addr};

endmodule

### rtl/srfp_ram.sv
// ----------------------------------------------------------------------------
// srfp_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module srfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/srfp_frame.sv
// ----------------------------------------------------------------------------
// srfp_frame - byte framing and value preparation
// Tracks the frame being received, checks length and check byte, and turns
// each beat into a decoded operation for the table stage.
// ----------------------------------------------------------------------------
module srfp_frame #(
   parameter int MAX_ADDR = srfp_pkg::MaxAddrDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                opcode,
   input  logic [7:0]          rx_byte,
   input  logic [7:0]          query_addr,
   input  logic                csr_we,
   input  logic [7:0]          csr_wdata,
   output srfp_pkg::op_type    op
);

   localparam logic [7:0] MaxAddr8 = 8'(MAX_ADDR);

   logic [7:0]         check_ff;
   logic [3:0]         bc_ff, bc_in;
   logic [3:0]         el_ff, el_in;
   logic [7:0]         fb_ff [8];
   logic               fb_wr;
   logic signed [20:0] speed_pre_ff;
   logic [31:0]        prod_ff;
   logic [3:0]         nbc;
   logic [3:0]         len;
   logic               data_beat;
   logic [19:0]        speed_mag;
   logic [31:0]        counts;
   logic [31:0]        ang;

   assign nbc       = bc_ff + 4'd1;
   assign len       = srfp_pkg::frame_len(rx_byte);
   assign data_beat = !opcode && (bc_ff != 4'd0) && !bc_ff[3];
   assign speed_mag = 20'({fb_ff[3], rx_byte}) * 20'(srfp_pkg::SpeedScale);
   assign counts    = {fb_ff[3], fb_ff[4], fb_ff[5], rx_byte};
   assign ang       = (prod_ff + srfp_pkg::HalfRev) >> srfp_pkg::RevShift;

   always_comb begin
      op    = '0;
      bc_in = bc_ff;
      el_in = el_ff;
      fb_wr = 1'b0;
      if (opcode) begin
         op.kind     = srfp_pkg::KindQuery;
         op.addr     = query_addr;
         op.in_range = (query_addr <= MaxAddr8);
      end else begin
         op.kind = srfp_pkg::KindByte;
         priority if (bc_ff == 4'd0) begin
            if (rx_byte != 8'd0 && rx_byte <= MaxAddr8) begin
               fb_wr = 1'b1;
               bc_in = 4'd1;
            end
         end else if (bc_ff[3]) begin
            bc_in = 4'd0;
            el_in = 4'd0;
         end else begin
            fb_wr = 1'b1;
            bc_in = nbc;
            priority if (nbc == 4'd2) begin
               el_in = len;
               if (len == 4'd0) begin
                  bc_in = 4'd0;
               end
            end else if (nbc < el_ff) begin
               bc_in = nbc;
            end else if (nbc != el_ff || rx_byte != check_ff) begin
               bc_in = 4'd0;
               el_in = 4'd0;
            end else begin
               // Complete frame with a good check byte.
               bc_in       = 4'd0;
               el_in       = 4'd0;
               op.kind     = srfp_pkg::KindFrame;
               op.addr     = fb_ff[0];
               op.cmd      = fb_ff[1];
               op.in_range = 1'b1;
               op.wr_speed = (fb_ff[1] == srfp_pkg::CmdSpeed);
               op.wr_pos   = (fb_ff[1] == srfp_pkg::CmdPosition);
               op.speed    = speed_pre_ff;
               op.pos      = (fb_ff[2] != 8'd0) ? 32'd0 - ang : ang;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ff <= srfp_pkg::CheckReset;
         bc_ff    <= 4'd0;
         el_ff    <= 4'd0;
      end else begin
         if (csr_we) begin
            check_ff <= csr_wdata;
         end
         if (accept) begin
            bc_ff <= bc_in;
            el_ff <= el_in;
         end
      end
   end

   // Frame bytes and the values prepared ahead of the check byte.
   always_ff @(posedge clock) begin
      if (accept && fb_wr) begin
         fb_ff[bc_ff[2:0]] <= rx_byte;
      end
      if (accept && data_beat && nbc == 4'd5) begin
         speed_pre_ff <= (fb_ff[2] != 8'd0) ? 21'd0 - {1'b0, speed_mag} : {1'b0, speed_mag};
      end
      if (accept && data_beat && nbc == 4'd7) begin
         prod_ff <= 32'(counts * 32'(srfp_pkg::PosScale));
      end
   end

endmodule

### rtl/srfp_table.sv
// ----------------------------------------------------------------------------
// srfp_table - per-drive status table and result register
// Reads the addressed row as a beat enters, merges new values once the beat
// is registered, writes the row back and loads the result register.
// ----------------------------------------------------------------------------
module srfp_table #(
   parameter int MAX_ADDR = srfp_pkg::MaxAddrDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  srfp_pkg::op_type  op_in,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_addr,
   output logic [7:0]        rsp_cmd,
   output srfp_pkg::row_type rsp_row
);

   localparam int Depth = MAX_ADDR + 1;
   localparam int AW    = $clog2(Depth);

   srfp_pkg::op_type  op_ff;
   logic              op_valid_ff;
   logic              vld_rd_ff;
   logic              byp_hit_ff;
   srfp_pkg::row_type byp_row_ff;
   logic [Depth-1:0]  vld_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_kind_ff;
   logic [7:0]        rsp_addr_ff;
   logic [7:0]        rsp_cmd_ff;
   srfp_pkg::row_type rsp_row_ff, rsp_row_in;

   logic              move;
   logic              accept;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic              ram_we;
   srfp_pkg::row_type ram_rd;
   srfp_pkg::row_type old_row;
   srfp_pkg::row_type new_row;

   assign move     = op_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign in_ready = !op_valid_ff || move;
   assign accept   = in_valid && in_ready;
   assign rd_addr  = op_in.in_range ? op_in.addr[AW-1:0] : '0;
   assign wr_addr  = op_ff.addr[AW-1:0];
   assign ram_we   = move && op_ff.in_range && (op_ff.wr_speed || op_ff.wr_pos);

   always_comb begin
      old_row = byp_hit_ff ? byp_row_ff : (vld_rd_ff ? ram_rd : '0);
      new_row = old_row;
      if (op_ff.wr_speed) begin
         new_row.speed = op_ff.speed;
      end
      if (op_ff.wr_pos) begin
         new_row.pos    = op_ff.pos;
         new_row.update = old_row.update + 16'd1;
      end
      rsp_row_in = op_ff.in_range ? new_row : '0;
   end

   srfp_ram #(
      .WIDTH ($bits(srfp_pkg::row_type)),
      .DEPTH (Depth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (new_row),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         if (accept) begin
            op_valid_ff <= 1'b1;
         end else if (move) begin
            op_valid_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ram_we) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // A row written in the same cycle as it is read is taken from the bypass.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_in;
         vld_rd_ff  <= vld_ff[rd_addr];
         byp_hit_ff <= ram_we && (wr_addr == rd_addr);
         byp_row_ff <= new_row;
      end
      if (move) begin
         rsp_kind_ff <= op_ff.kind;
         rsp_addr_ff <= op_ff.addr;
         rsp_cmd_ff  <= op_ff.cmd;
         rsp_row_ff  <= rsp_row_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_addr  = rsp_addr_ff;
   assign rsp_cmd   = rsp_cmd_ff;
   assign rsp_row   = rsp_row_ff;

`ifndef SYNTHESIS
   a_write_only_frames: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (op_ff.kind == srfp_pkg::KindFrame && op_valid_ff))
      else $error("table written by a beat that is not an accepted frame");

   a_written_row_valid: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> vld_ff[$past(wr_addr)])
      else $error("written row not marked valid");

   a_result_from_move: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(move))
      else $error("result appeared without an operation leaving the table stage");
`endif

endmodule
